>>> hdl/csc_pkg.sv
// Shared types and constants for the countdown timer and stopwatch controller.
`default_nettype none

package csc_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned HOLD_W = 8;
  localparam int unsigned LP_W   = 4;
  localparam int unsigned MIN_W  = 7;
  localparam int unsigned SEC_W  = 6;
  localparam int unsigned HSEC_W = 7;
  localparam int unsigned PRE_W  = 7;

  localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
  localparam logic [OP_W-1:0] OP_B1      = 3'd1;
  localparam logic [OP_W-1:0] OP_B2      = 3'd2;
  localparam logic [OP_W-1:0] OP_B3_REL  = 3'd3;
  localparam logic [OP_W-1:0] OP_B12_REL = 3'd4;

  localparam logic [LP_W-1:0]   LONG_PRESS_RESET = 4'd3;
  localparam logic [SEC_W-1:0]  SEC_CAP          = 6'd59;
  localparam logic [MIN_W-1:0]  MIN_CAP          = 7'd59;
  localparam logic [MIN_W-1:0]  MIN_LAST         = 7'd99;
  localparam logic [HSEC_W-1:0] HSEC_LAST        = 7'd99;
  localparam logic [PRE_W-1:0]  PRE_LAST         = 7'd99;

  typedef struct packed {
    logic              mode;
    logic [MIN_W-1:0]  min;
    logic [SEC_W-1:0]  sec;
    logic [HSEC_W-1:0] hsec;
    logic [PRE_W-1:0]  pre;
    logic              running;
    logic              alarm;
    logic              blink;
  } csc_state_t;

  typedef struct packed {
    logic [MIN_W-1:0]  minutes;
    logic [SEC_W-1:0]  seconds;
    logic [HSEC_W-1:0] hundredths;
    logic              stopwatch_mode;
    logic              running;
    logic              alarm_on;
    logic              led;
  } csc_result_t;

endpackage

`default_nettype wire

>>> hdl/csc_if.sv
// Request and result channel interfaces for the timer controller.
`default_nettype none

interface csc_req_if;
  logic                          valid;
  logic                          ready;
  logic [csc_pkg::OP_W-1:0]      opcode;
  logic [csc_pkg::HOLD_W-1:0]    hold_seconds;

  modport source (output valid, output opcode, output hold_seconds, input ready);
  modport sink   (input valid, input opcode, input hold_seconds, output ready);
endinterface

interface csc_res_if;
  logic                          valid;
  logic                          ready;
  logic [csc_pkg::MIN_W-1:0]     minutes;
  logic [csc_pkg::SEC_W-1:0]     seconds;
  logic [csc_pkg::HSEC_W-1:0]    hundredths;
  logic                          stopwatch_mode;
  logic                          running;
  logic                          alarm_on;
  logic                          led;

  modport source (output valid, output minutes, output seconds, output hundredths,
                  output stopwatch_mode, output running, output alarm_on, output led,
                  input ready);
  modport sink   (input valid, input minutes, input seconds, input hundredths,
                  input stopwatch_mode, input running, input alarm_on, input led,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/csc_core.sv
// Timer state registers and the per-request update logic.
`default_nettype none

module csc_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       fire,
  input  wire logic [csc_pkg::OP_W-1:0]   op,
  input  wire logic [csc_pkg::HOLD_W-1:0] hold,
  input  wire logic [csc_pkg::LP_W-1:0]   long_press,
  output csc_pkg::csc_result_t            res
);

  csc_pkg::csc_state_t st_r;
  csc_pkg::csc_state_t st_nxt;
  logic                is_long;

  assign is_long = hold > {{(csc_pkg::HOLD_W-csc_pkg::LP_W){1'b0}}, long_press};

  always_comb begin
    st_nxt = st_r;
    case (op)
      csc_pkg::OP_TICK: begin
        if (st_r.running) begin
          if (st_r.mode) begin
            if (st_r.hsec == csc_pkg::HSEC_LAST) begin
              st_nxt.hsec = '0;
              if (st_r.sec == csc_pkg::SEC_CAP) begin
                st_nxt.sec = '0;
                st_nxt.min = (st_r.min == csc_pkg::MIN_LAST) ? '0 : st_r.min + 1'b1;
              end else begin
                st_nxt.sec = st_r.sec + 1'b1;
              end
            end else begin
              st_nxt.hsec = st_r.hsec + 1'b1;
            end
          end else begin
            if (st_r.pre == csc_pkg::PRE_LAST) begin
              st_nxt.pre   = '0;
              st_nxt.blink = ~st_r.blink;
              if (st_r.sec != '0) begin
                st_nxt.sec = st_r.sec - 1'b1;
              end else if (st_r.min != '0) begin
                st_nxt.min = st_r.min - 1'b1;
                st_nxt.sec = csc_pkg::SEC_CAP;
              end
              if (st_nxt.min == '0 && st_nxt.sec == '0) begin
                st_nxt.alarm   = 1'b1;
                st_nxt.running = 1'b0;
              end
            end else begin
              st_nxt.pre = st_r.pre + 1'b1;
            end
          end
        end
      end
      csc_pkg::OP_B1: begin
        if (st_r.mode) begin
          st_nxt.running = ~st_r.running;
        end else begin
          st_nxt.alarm = 1'b0;
          if (st_r.min < csc_pkg::MIN_CAP) st_nxt.min = st_r.min + 1'b1;
        end
      end
      csc_pkg::OP_B2: begin
        if (st_r.mode) begin
          st_nxt.running = 1'b0;
          st_nxt.min     = '0;
          st_nxt.sec     = '0;
          st_nxt.hsec    = '0;
          st_nxt.pre     = '0;
        end else begin
          st_nxt.alarm = 1'b0;
          if (st_r.sec < csc_pkg::SEC_CAP) st_nxt.sec = st_r.sec + 1'b1;
        end
      end
      csc_pkg::OP_B3_REL: begin
        if (!st_r.mode) begin
          if (is_long) begin
            st_nxt.alarm   = 1'b0;
            st_nxt.running = 1'b0;
            st_nxt.min     = '0;
            st_nxt.sec     = '0;
            st_nxt.hsec    = '0;
            st_nxt.pre     = '0;
          end else if (st_r.running) begin
            st_nxt.running = 1'b0;
          end else if (st_r.min != '0 || st_r.sec != '0) begin
            st_nxt.running = 1'b1;
            st_nxt.pre     = '0;
            st_nxt.blink   = 1'b1;
          end
        end
      end
      csc_pkg::OP_B12_REL: begin
        if (is_long) begin
          st_nxt.mode    = ~st_r.mode;
          st_nxt.alarm   = 1'b0;
          st_nxt.running = 1'b0;
          st_nxt.blink   = 1'b0;
          st_nxt.min     = '0;
          st_nxt.sec     = '0;
          st_nxt.hsec    = '0;
          st_nxt.pre     = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.minutes        = st_nxt.min;
    res.seconds        = st_nxt.sec;
    res.hundredths     = st_nxt.mode ? st_nxt.hsec : '0;
    res.stopwatch_mode = st_nxt.mode;
    res.running        = st_nxt.running;
    res.alarm_on       = st_nxt.alarm;
    if (st_nxt.alarm) begin
      res.led = 1'b1;
    end else if (st_nxt.running) begin
      res.led = st_nxt.mode ? 1'b1 : st_nxt.blink;
    end else begin
      res.led = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.sec <= csc_pkg::SEC_CAP)
    else $error("second count out of range");

  a_tick_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.hsec <= csc_pkg::HSEC_LAST && st_r.pre <= csc_pkg::PRE_LAST)
    else $error("sub-second counter out of range");

  a_cd_no_hsec: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.mode |-> st_r.hsec == '0 && st_r.min <= csc_pkg::MIN_CAP)
    else $error("countdown mode with stopwatch residue");

  a_alarm_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.alarm |-> !st_r.running && !st_r.mode && st_r.min == '0 && st_r.sec == '0)
    else $error("alarm raised while counting or with time left");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(fire) && $past(rst_n) |-> $stable(st_r))
    else $error("state moved without a request");

endmodule

`default_nettype wire

>>> hdl/countdown_stopwatch_controller.sv
// Top level of the countdown timer and stopwatch controller.
// Usage:
//   in_req carries one request per handshake: opcode (tick, button 1, button 2,
//   button 3 release, buttons 1+2 release) and hold_seconds for releases.
//   out_res returns exactly one result per request: minutes, seconds,
//   hundredths, stopwatch_mode, running, alarm_on and led, after the update.
//   cfg_we/cfg_wdata set the long-press threshold (reset value 3 seconds);
//   write it only while no request is in flight.
// Timing: a request accepted into the input register is loaded into the result
//   register when it fires, and its result is then valid on out_res.
// Throughput: one request per cycle unless out_res.ready stalls; the input
//   register and the result register separate the two channels.
// Reset: rst_n (synchronous) clears all timer state, both registers' valid
//   flags and restores the threshold.
// Stall: while out_res.ready is low the result holds, one more request is
//   taken into the input register, then in_req.ready drops.
`default_nettype none

module countdown_stopwatch_controller (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  csc_req_if.sink                       in_req,
  csc_res_if.source                     out_res,
  input  wire logic                     cfg_we,
  input  wire logic [csc_pkg::LP_W-1:0] cfg_wdata
);

  logic                         in_v_r;
  logic [csc_pkg::OP_W-1:0]     in_op_r;
  logic [csc_pkg::HOLD_W-1:0]   in_hold_r;
  logic                         out_v_r;
  csc_pkg::csc_result_t         out_r;
  csc_pkg::csc_result_t         res;
  logic [csc_pkg::LP_W-1:0]     long_press_r;
  logic                         advance;
  logic                         fire;

  assign advance      = !out_v_r || out_res.ready;
  assign fire         = in_v_r && advance;
  assign in_req.ready = !in_v_r || fire;

  csc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .op         (in_op_r),
    .hold       (in_hold_r),
    .long_press (long_press_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
      long_press_r <= csc_pkg::LONG_PRESS_RESET;
    end else begin
      if (in_req.ready) in_v_r <= in_req.valid;
      if (fire) begin
        out_v_r <= 1'b1;
      end else if (out_res.ready) begin
        out_v_r <= 1'b0;
      end
      if (cfg_we) long_press_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.ready && in_req.valid) begin
      in_op_r   <= in_req.opcode;
      in_hold_r <= in_req.hold_seconds;
    end
    if (fire) out_r <= res;
  end

  assign out_res.valid          = out_v_r;
  assign out_res.minutes        = out_r.minutes;
  assign out_res.seconds        = out_r.seconds;
  assign out_res.hundredths     = out_r.hundredths;
  assign out_res.stopwatch_mode = out_r.stopwatch_mode;
  assign out_res.running        = out_r.running;
  assign out_res.alarm_on       = out_r.alarm_on;
  assign out_res.led            = out_r.led;

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for the countdown timer and stopwatch controller.
module tb_top;

  localparam int OP_W   = csc_pkg::OP_W;
  localparam int HOLD_W = csc_pkg::HOLD_W;
  localparam int LP_W   = csc_pkg::LP_W;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [HOLD_W-1:0] hold;
  } timer_req_t;

  localparam int HOLDOFF_CYCLES = 80;
  localparam int IDLE_PCT       = 35;
  localparam int PHASE_REQS     = 360;
  localparam int MAX_REPORTS    = 10;
  localparam int NUM_PHASES     = 5;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            cfg_we;
  logic [LP_W-1:0] cfg_wdata;

  csc_req_if req_ch();
  csc_res_if res_ch();

  countdown_stopwatch_controller u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_ch),
    .out_res   (res_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  timer_req_t           pending_q[$];
  csc_pkg::csc_result_t display_q[$];
  csc_pkg::csc_state_t  timer_now;
  csc_pkg::csc_state_t  plan_timer;
  logic [LP_W-1:0]      long_thr_live;
  logic [LP_W-1:0]      long_thr_plan;
  bit                   tx_jitter;
  bit                   rx_jitter;
  bit                   holdoff_start;
  int                   holdoff_left = 0;
  int                   plan_changes = 0;
  int                   n_accepted   = 0;
  int                   n_checked    = 0;
  int                   n_mismatch   = 0;
  int                   n_alarm      = 0;
  int                   n_rollover   = 0;

  always #2 clk = ~clk;

  function automatic void zero_time(inout csc_pkg::csc_state_t s);
    s.min  = '0;
    s.sec  = '0;
    s.hsec = '0;
    s.pre  = '0;
  endfunction

  function automatic csc_pkg::csc_result_t step_timer(inout csc_pkg::csc_state_t s,
                                                      input logic [OP_W-1:0] op,
                                                      input logic [HOLD_W-1:0] hold,
                                                      input logic [LP_W-1:0] thr);
    logic                 is_long;
    csc_pkg::csc_result_t r;
    is_long = hold > HOLD_W'(thr);
    case (op)
      csc_pkg::OP_TICK: begin
        if (s.running && s.mode) begin
          if (s.hsec == csc_pkg::HSEC_LAST) begin
            s.hsec = '0;
            if (s.sec == csc_pkg::SEC_CAP) begin
              s.sec = '0;
              s.min = (s.min == csc_pkg::MIN_LAST) ? '0 : s.min + 1'b1;
            end else begin
              s.sec = s.sec + 1'b1;
            end
          end else begin
            s.hsec = s.hsec + 1'b1;
          end
        end else if (s.running) begin
          if (s.pre == csc_pkg::PRE_LAST) begin
            s.pre   = '0;
            s.blink = ~s.blink;
            if (s.sec != 0) begin
              s.sec = s.sec - 1'b1;
            end else if (s.min != 0) begin
              s.min = s.min - 1'b1;
              s.sec = csc_pkg::SEC_CAP;
            end
            if (s.min == 0 && s.sec == 0) begin
              s.alarm   = 1'b1;
              s.running = 1'b0;
            end
          end else begin
            s.pre = s.pre + 1'b1;
          end
        end
      end
      csc_pkg::OP_B1: begin
        if (s.mode) begin
          s.running = ~s.running;
        end else begin
          s.alarm = 1'b0;
          if (s.min < csc_pkg::MIN_CAP) s.min = s.min + 1'b1;
        end
      end
      csc_pkg::OP_B2: begin
        if (s.mode) begin
          s.running = 1'b0;
          zero_time(s);
        end else begin
          s.alarm = 1'b0;
          if (s.sec < csc_pkg::SEC_CAP) s.sec = s.sec + 1'b1;
        end
      end
      csc_pkg::OP_B3_REL: begin
        if (!s.mode) begin
          if (is_long) begin
            s.alarm   = 1'b0;
            s.running = 1'b0;
            zero_time(s);
          end else if (s.running) begin
            s.running = 1'b0;
          end else if (s.min != 0 || s.sec != 0) begin
            s.running = 1'b1;
            s.pre     = '0;
            s.blink   = 1'b1;
          end
        end
      end
      csc_pkg::OP_B12_REL: begin
        if (is_long) begin
          s.mode    = ~s.mode;
          s.alarm   = 1'b0;
          s.running = 1'b0;
          s.blink   = 1'b0;
          zero_time(s);
        end
      end
      default: begin
      end
    endcase
    r.minutes        = s.min;
    r.seconds        = s.sec;
    r.hundredths     = s.mode ? s.hsec : '0;
    r.stopwatch_mode = s.mode;
    r.running        = s.running;
    r.alarm_on       = s.alarm;
    r.led            = s.alarm ? 1'b1 : (s.running ? (s.mode ? 1'b1 : s.blink) : 1'b0);
    return r;
  endfunction

  function automatic logic [HOLD_W-1:0] long_hold();
    if ($urandom_range(1)) return HOLD_W'(long_thr_plan) + 1'b1;
    return HOLD_W'($urandom_range(255, int'(long_thr_plan) + 1));
  endfunction

  function automatic logic [HOLD_W-1:0] short_hold();
    if ($urandom_range(1)) return HOLD_W'(long_thr_plan);
    return HOLD_W'($urandom_range(int'(long_thr_plan), 0));
  endfunction

  task automatic plan_req(input logic [OP_W-1:0] op, input logic [HOLD_W-1:0] hold);
    csc_pkg::csc_state_t  prior;
    csc_pkg::csc_result_t unused;
    timer_req_t           item;
    prior     = plan_timer;
    unused    = step_timer(plan_timer, op, hold, long_thr_plan);
    item.op   = op;
    item.hold = hold;
    pending_q.push_back(item);
    if (plan_timer != prior) plan_changes++;
  endtask

  task automatic plan_mode(input logic m);
    if (plan_timer.mode != m) plan_req(csc_pkg::OP_B12_REL, long_hold());
  endtask

  task automatic plan_button();
    case ($urandom_range(2))
      0: plan_req(csc_pkg::OP_B1, HOLD_W'($urandom));
      1: plan_req(csc_pkg::OP_B2, HOLD_W'($urandom));
      default: plan_req(csc_pkg::OP_B3_REL, short_hold());
    endcase
  endtask

  task automatic plan_ticks(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(32) == 0) plan_button();
      else plan_req(csc_pkg::OP_TICK, HOLD_W'($urandom));
    end
  endtask

  task automatic plan_seq();
    int              kind;
    int              n;
    int              span;
    logic [OP_W-1:0] op;
    kind = $urandom_range(99);
    if (kind < 40) begin
      plan_mode(1'b0);
      if ($urandom_range(1)) plan_req(csc_pkg::OP_B3_REL, long_hold());
      if ($urandom_range(9) == 0) plan_req(csc_pkg::OP_B1, HOLD_W'($urandom));
      repeat ($urandom_range(3, 1)) plan_req(csc_pkg::OP_B2, HOLD_W'($urandom));
      plan_req(csc_pkg::OP_B3_REL, short_hold());
      span = plan_timer.min * 6000 + plan_timer.sec * 100;
      if (span <= 400 && $urandom_range(9) < 7) n = span + $urandom_range(30);
      else n = $urandom_range(250, 1);
      plan_ticks(n);
      if ($urandom_range(1)) plan_button();
    end else if (kind < 65) begin
      plan_mode(1'b1);
      plan_req(csc_pkg::OP_B1, HOLD_W'($urandom));
      plan_ticks($urandom_range(300, 1));
      if ($urandom_range(1)) plan_req(csc_pkg::OP_B2, HOLD_W'($urandom));
    end else if (kind < 75) begin
      plan_mode(1'b0);
      op = $urandom_range(1) ? csc_pkg::OP_B1 : csc_pkg::OP_B2;
      repeat ($urandom_range(65, 55)) plan_req(op, HOLD_W'($urandom));
      plan_req(csc_pkg::OP_B3_REL, long_hold());
    end else if (kind < 85) begin
      plan_req(csc_pkg::OP_B12_REL, short_hold());
      plan_req(csc_pkg::OP_B3_REL, short_hold());
      plan_req(csc_pkg::OP_B3_REL, long_hold());
      plan_req(csc_pkg::OP_B12_REL, long_hold());
    end else begin
      repeat ($urandom_range(8, 1)) plan_req(OP_W'($urandom_range(7)), HOLD_W'($urandom));
    end
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || req_ch.valid || display_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      n_mismatch++;
      if (n_mismatch <= MAX_REPORTS)
        $display("result %0d: %s expected %0d, got %0d", n_checked, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin : drive_requests
    csc_pkg::csc_state_t prior;
    timer_req_t          item;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        prior = timer_now;
        display_q.push_back(step_timer(timer_now, req_ch.opcode, req_ch.hold_seconds,
                                       long_thr_live));
        n_accepted++;
        if (!prior.alarm && timer_now.alarm) n_alarm++;
        if (req_ch.opcode == csc_pkg::OP_TICK && prior.mode &&
            prior.min == csc_pkg::MIN_LAST && timer_now.min == 0) n_rollover++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_q.size() != 0 && !(tx_jitter && $urandom_range(99) < IDLE_PCT)) begin
          item = pending_q.pop_front();
          req_ch.valid        <= 1'b1;
          req_ch.opcode       <= item.op;
          req_ch.hold_seconds <= item.hold;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : pace_results
    if (holdoff_start) begin
      holdoff_left  = HOLDOFF_CYCLES;
      holdoff_start = 1'b0;
    end
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= !(rx_jitter && $urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_results
    csc_pkg::csc_result_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (display_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS)
          $display("unexpected result %0d:%0d.%0d", res_ch.minutes, res_ch.seconds,
                   res_ch.hundredths);
      end else begin
        want = display_q.pop_front();
        n_checked++;
        compare_field("minutes", 32'(want.minutes), 32'(res_ch.minutes));
        compare_field("seconds", 32'(want.seconds), 32'(res_ch.seconds));
        compare_field("hundredths", 32'(want.hundredths), 32'(res_ch.hundredths));
        compare_field("stopwatch_mode", 32'(want.stopwatch_mode),
                      32'(res_ch.stopwatch_mode));
        compare_field("running", 32'(want.running), 32'(res_ch.running));
        compare_field("alarm_on", 32'(want.alarm_on), 32'(res_ch.alarm_on));
        compare_field("led", 32'(want.led), 32'(res_ch.led));
      end
    end
  end

  initial begin
    #16_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [LP_W-1:0] thr_list[NUM_PHASES];
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    timer_now           = '0;
    plan_timer          = '0;
    long_thr_live       = csc_pkg::LONG_PRESS_RESET;
    long_thr_plan       = csc_pkg::LONG_PRESS_RESET;
    tx_jitter           = 1'b0;
    rx_jitter           = 1'b0;
    holdoff_start       = 1'b0;
    thr_list = '{4'd0, 4'd15, 4'd1, LP_W'($urandom_range(14, 2)),
                 LP_W'($urandom_range(15, 1))};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    plan_req(3'd5, 8'hFF);
    plan_req(3'd7, 8'h00);
    plan_req(3'd6, 8'h5A);
    plan_req(csc_pkg::OP_TICK, 8'hFF);
    plan_req(csc_pkg::OP_B3_REL, 8'd0);
    plan_req(csc_pkg::OP_B12_REL, 8'd3);
    plan_req(csc_pkg::OP_B2, 8'd0);
    plan_req(csc_pkg::OP_B1, 8'd0);
    plan_req(csc_pkg::OP_B3_REL, 8'd3);
    plan_req(csc_pkg::OP_B2, 8'd0);
    plan_req(csc_pkg::OP_TICK, 8'd0);
    plan_req(csc_pkg::OP_B3_REL, 8'd2);
    plan_req(csc_pkg::OP_B3_REL, 8'd4);
    plan_req(csc_pkg::OP_B12_REL, 8'd4);
    plan_req(csc_pkg::OP_B3_REL, 8'd0);
    plan_req(csc_pkg::OP_B1, 8'd0);
    plan_req(csc_pkg::OP_TICK, 8'd0);
    plan_req(csc_pkg::OP_TICK, 8'd0);
    plan_req(csc_pkg::OP_B1, 8'd0);
    plan_req(csc_pkg::OP_TICK, 8'd0);
    plan_req(csc_pkg::OP_B2, 8'd0);
    plan_req(csc_pkg::OP_B12_REL, 8'hFF);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_wdata <= thr_list[p];
      @(posedge clk);
      cfg_we        <= 1'b0;
      long_thr_live  = thr_list[p];
      @(negedge clk);
      long_thr_plan = thr_list[p];
      if (p == 1) begin
        tx_jitter     = 1'b1;
        rx_jitter     = 1'b1;
        holdoff_start = 1'b1;
      end
      plan_changes = 0;
      while (plan_changes < PHASE_REQS) plan_seq();
      drain();
    end

    repeat (8) @(posedge clk);
    $display("timer run: %0d requests, %0d results checked, %0d mismatches",
             n_accepted, n_checked, n_mismatch);
    $display("long-press thresholds 3 %0d %0d %0d %0d %0d; %0d alarms, %0d minute rollovers",
             thr_list[0], thr_list[1], thr_list[2], thr_list[3], thr_list[4],
             n_alarm, n_rollover);
    if (n_mismatch == 0 && display_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
